>>> src/refcounted_channel_slot_allocator_assert.svh
// Assertion macros for the channel slot allocator.
// Included by the top level; needs nothing else.
`ifndef REFCOUNTED_CHANNEL_SLOT_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_CHANNEL_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define RCSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define RCSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rcsa_pkg.sv
// Shared types and codes for the channel slot allocator.
// No dependencies; used by every module of the block.
package rcsa_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_CONNECT    = 2'd0,
    OP_DISCONNECT = 2'd1,
    OP_QUERY      = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_ID   = 3'd1,
    ST_CAP      = 3'd2,
    ST_NOSLOT   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  // Register map (word index)
  localparam logic REG_MAX_CAPACITY = 1'b0;

  // Search token control, handed from cell to cell
  typedef struct packed {
    logic act;  // token carries a live search
    logic hit;  // an earlier cell matched
  } tok_ctl_t;

  // Entry write control, broadcast to all cells
  typedef struct packed {
    logic we;     // write the addressed entry
    logic valid;  // new valid bit for it
  } wr_ctl_t;

  // Free stack commands
  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

endpackage

>>> src/rcsa_cell.sv
// One slot entry of the allocator: holds valid, key, count, capacity.
// Compares the search token against its entry and passes it on.
// Depends on rcsa_pkg.
module rcsa_cell #(
  parameter int SlotW = 4,
  parameter int CntW  = 16,
  parameter int Index = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         key_i,
  input  rcsa_pkg::tok_ctl_t  tok_ctl_i,
  input  logic [SlotW-1:0]    tok_slot_i,
  input  logic [CntW-1:0]     tok_cnt_i,
  input  logic [15:0]         tok_cap_i,
  output rcsa_pkg::tok_ctl_t  tok_ctl_o,
  output logic [SlotW-1:0]    tok_slot_o,
  output logic [CntW-1:0]     tok_cnt_o,
  output logic [15:0]         tok_cap_o,
  input  rcsa_pkg::wr_ctl_t   wr_i,
  input  logic [SlotW-1:0]    wr_slot_i,
  input  logic [31:0]         wr_key_i,
  input  logic [CntW-1:0]     wr_cnt_i,
  input  logic [15:0]         wr_cap_i,
  output logic                valid_o
);

  localparam logic [SlotW-1:0] MySlot = SlotW'(Index);

  logic               valid_q;
  logic [31:0]        key_q;
  logic [CntW-1:0]    cnt_q;
  logic [15:0]        cap_q;
  rcsa_pkg::tok_ctl_t tok_ctl_q, tok_ctl_d;
  logic [SlotW-1:0]   tok_slot_q, tok_slot_d;
  logic [CntW-1:0]    tok_cnt_q, tok_cnt_d;
  logic [15:0]        tok_cap_q, tok_cap_d;
  logic               wr_me;
  logic               match;

  assign wr_me = wr_i.we && (wr_slot_i == MySlot);
  assign match = valid_q && (key_q == key_i);

  // Entry storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_me) begin
      valid_q <= wr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_me) begin
      key_q <= wr_key_i;
      cnt_q <= wr_cnt_i;
      cap_q <= wr_cap_i;
    end
  end

  // Token: first matching cell claims it, later cells pass it through
  always_comb begin
    tok_ctl_d  = tok_ctl_i;
    tok_slot_d = tok_slot_i;
    tok_cnt_d  = tok_cnt_i;
    tok_cap_d  = tok_cap_i;
    if (tok_ctl_i.act && !tok_ctl_i.hit && match) begin
      tok_ctl_d.hit = 1'b1;
      tok_slot_d    = MySlot;
      tok_cnt_d     = cnt_q;
      tok_cap_d     = cap_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_ctl_q <= '0;
    end else begin
      tok_ctl_q <= tok_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_slot_q <= tok_slot_d;
    tok_cnt_q  <= tok_cnt_d;
    tok_cap_q  <= tok_cap_d;
  end

  assign tok_ctl_o  = tok_ctl_q;
  assign tok_slot_o = tok_slot_q;
  assign tok_cnt_o  = tok_cnt_q;
  assign tok_cap_o  = tok_cap_q;
  assign valid_o    = valid_q;

endmodule

>>> src/rcsa_free_stack.sv
// LIFO stack of free slot indexes, reset full with slot N-1 on top.
// Depends on rcsa_pkg.
module rcsa_free_stack #(
  parameter int Depth  = 16,
  parameter int SlotW  = 4,
  parameter int DepthW = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcsa_pkg::stk_cmd_t  cmd_i,
  input  logic [SlotW-1:0]    push_slot_i,
  output logic [SlotW-1:0]    top_slot_o,
  output logic                empty_o,
  output logic [DepthW-1:0]   depth_o
);

  localparam logic [DepthW-1:0] DepthMax = DepthW'(Depth);

  logic [SlotW-1:0]  stack_q [Depth];
  logic [DepthW-1:0] depth_q;
  logic [SlotW-1:0]  pop_idx;
  logic [SlotW-1:0]  push_idx;
  logic              full;

  assign full     = (depth_q == DepthMax);
  assign empty_o  = (depth_q == '0);
  assign pop_idx  = SlotW'(depth_q - DepthW'(1));
  assign push_idx = SlotW'(depth_q);

  assign top_slot_o = stack_q[pop_idx];
  assign depth_o    = depth_q;

  // Stack entries and depth; a push onto a full stack is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        stack_q[i] <= SlotW'(i);
      end
      depth_q <= DepthMax;
    end else if (cmd_i.pop && !empty_o) begin
      depth_q <= depth_q - DepthW'(1);
    end else if (cmd_i.push && !full) begin
      stack_q[push_idx] <= push_slot_i;
      depth_q           <= depth_q + DepthW'(1);
    end
  end

endmodule

>>> src/refcounted_channel_slot_allocator.sv
// Reference-counted channel slot allocator: top level with control, APB port and cell chain.
// Depends on rcsa_pkg, rcsa_cell, rcsa_free_stack and the assertion header.
//
// Each request beat (connect, disconnect or query of a 32-bit channel ID) is looked up
// by a search token. The token enters a chain of CHANNELS entry cells the cycle after
// acceptance, once the request register holds the new key, and moves one cell per clock.
// The lookup at the end of the chain is then latched, and the update is applied as the
// result register is loaded. A new request is taken only once the previous one has left
// the update stage, even while the previous result still waits to be taken; a stalled
// result holds back only the update of the next request. Only one request is looked up
// at a time. max_capacity sits at byte address 0 of the APB port and may be written only
// while the block is idle.
`include "refcounted_channel_slot_allocator_assert.svh"

module refcounted_channel_slot_allocator #(
  parameter int CHANNELS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] channel_id_i,
  input  logic [15:0] capacity_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [15:0] connections_o,
  output logic [15:0] stored_capacity_o,
  output logic        capacity_mismatch_o,
  output logic        created_o,
  output logic        released_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SlotW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DepthW = $clog2(CHANNELS + 1);
  localparam int CntW   = COUNT_BITS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Request and lookup result registers
  rcsa_pkg::op_e    op_q;
  logic [31:0]      id_q;
  logic [15:0]      cap_q;
  logic             launch_q;
  logic             hit_q;
  logic [SlotW-1:0] rslot_q;
  logic [CntW-1:0]  rcnt_q;
  logic [15:0]      rcap_q;
  logic [15:0]      max_cap_q;

  // Result register
  logic                out_valid_q;
  rcsa_pkg::status_e   status_q, status_d;
  logic [3:0]          slot_q, slot_d;
  logic [15:0]         conn_q, conn_d;
  logic [15:0]         scap_q, scap_d;
  logic                mis_q, mis_d;
  logic                cre_q, cre_d;
  logic                rel_q, rel_d;

  // Chain wiring
  rcsa_pkg::tok_ctl_t tok_ctl  [CHANNELS+1];
  logic [SlotW-1:0]   tok_slot [CHANNELS+1];
  logic [CntW-1:0]    tok_cnt  [CHANNELS+1];
  logic [15:0]        tok_cap  [CHANNELS+1];
  logic [CHANNELS-1:0] valid_vec;

  rcsa_pkg::wr_ctl_t  wr;
  logic [SlotW-1:0]   wr_slot;
  logic [CntW-1:0]    wr_cnt;
  logic [15:0]        wr_cap;

  rcsa_pkg::stk_cmd_t stk_cmd;
  logic [SlotW-1:0]   stk_top;
  logic               stk_empty;
  logic [DepthW-1:0]  stk_depth;

  logic               in_acc;
  logic               fire;
  logic               found;
  logic               cnt_full;
  logic [CntW-1:0]    cnt_dec;
  logic [31:0]        slot_ext;
  logic [31:0]        cnt_ext;
  logic               cfg_wr;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fire       = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // APB register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == rcsa_pkg::REG_MAX_CAPACITY) ? {16'b0, max_cap_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cap_q <= 16'hFFFF;
    end else if (cfg_wr && (paddr[2] == rcsa_pkg::REG_MAX_CAPACITY)) begin
      max_cap_q <= pwdata[15:0];
    end
  end

  // Token launch into the first cell, the cycle after accept so id_q holds the new key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= 1'b0;
    end else begin
      launch_q <= in_acc;
    end
  end

  assign tok_ctl[0].act = launch_q;
  assign tok_ctl[0].hit = 1'b0;
  assign tok_slot[0]    = '0;
  assign tok_cnt[0]     = '0;
  assign tok_cap[0]     = '0;

  // Entry cell chain
  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    rcsa_cell #(
      .SlotW (SlotW),
      .CntW  (CntW),
      .Index (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .key_i      (id_q),
      .tok_ctl_i  (tok_ctl[g]),
      .tok_slot_i (tok_slot[g]),
      .tok_cnt_i  (tok_cnt[g]),
      .tok_cap_i  (tok_cap[g]),
      .tok_ctl_o  (tok_ctl[g+1]),
      .tok_slot_o (tok_slot[g+1]),
      .tok_cnt_o  (tok_cnt[g+1]),
      .tok_cap_o  (tok_cap[g+1]),
      .wr_i       (wr),
      .wr_slot_i  (wr_slot),
      .wr_key_i   (id_q),
      .wr_cnt_i   (wr_cnt),
      .wr_cap_i   (wr_cap),
      .valid_o    (valid_vec[g])
    );
  end

  rcsa_free_stack #(
    .Depth  (CHANNELS),
    .SlotW  (SlotW),
    .DepthW (DepthW)
  ) u_free_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (stk_cmd),
    .push_slot_i (rslot_q),
    .top_slot_o  (stk_top),
    .empty_o     (stk_empty),
    .depth_o     (stk_depth)
  );

  // Control FSM
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_SCAN;
      S_SCAN: if (tok_ctl[CHANNELS].act) state_d = S_DONE;
      S_DONE: if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request capture and lookup result capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= rcsa_pkg::op_e'(operation_i);
      id_q  <= channel_id_i;
      cap_q <= capacity_i;
    end
    if ((state_q == S_SCAN) && tok_ctl[CHANNELS].act) begin
      hit_q   <= tok_ctl[CHANNELS].hit;
      rslot_q <= tok_slot[CHANNELS];
      rcnt_q  <= tok_cnt[CHANNELS];
      rcap_q  <= tok_cap[CHANNELS];
    end
  end

  assign found    = hit_q && (id_q != 32'b0);
  assign cnt_full = (rcnt_q == {CntW{1'b1}});
  assign cnt_dec  = (rcnt_q != '0) ? (rcnt_q - CntW'(1)) : rcnt_q;

  // Update decision and result fields
  always_comb begin
    status_d    = rcsa_pkg::ST_OK;
    slot_ext    = 32'b0;
    cnt_ext     = 32'b0;
    scap_d      = 16'b0;
    mis_d       = 1'b0;
    cre_d       = 1'b0;
    rel_d       = 1'b0;
    wr.we       = 1'b0;
    wr.valid    = 1'b1;
    wr_slot     = rslot_q;
    wr_cnt      = rcnt_q;
    wr_cap      = rcap_q;
    stk_cmd     = '0;
    unique case (op_q)
      rcsa_pkg::OP_CONNECT: begin
        if (id_q == 32'b0) begin
          status_d = rcsa_pkg::ST_BAD_ID;
        end else if (cap_q > max_cap_q) begin
          status_d = rcsa_pkg::ST_CAP;
        end else if (found) begin
          slot_ext = 32'(rslot_q);
          scap_d   = rcap_q;
          mis_d    = (rcap_q != cap_q);
          if (cnt_full) begin
            status_d = rcsa_pkg::ST_FULL;
            cnt_ext  = 32'(rcnt_q);
          end else begin
            wr.we   = 1'b1;
            wr_cnt  = rcnt_q + CntW'(1);
            cnt_ext = 32'(wr_cnt);
          end
        end else if (stk_empty) begin
          status_d = rcsa_pkg::ST_NOSLOT;
        end else begin
          // new channel takes the top free slot
          wr.we       = 1'b1;
          wr_slot     = stk_top;
          wr_cnt      = CntW'(1);
          wr_cap      = cap_q;
          stk_cmd.pop = 1'b1;
          slot_ext    = 32'(stk_top);
          cnt_ext     = 32'(wr_cnt);
          scap_d      = cap_q;
          cre_d       = 1'b1;
        end
      end
      rcsa_pkg::OP_DISCONNECT: begin
        if (!found) begin
          status_d = rcsa_pkg::ST_NOTFOUND;
        end else begin
          wr.we        = 1'b1;
          wr_cnt       = cnt_dec;
          wr.valid     = (cnt_dec != '0);
          rel_d        = (cnt_dec == '0);
          stk_cmd.push = rel_d;
          slot_ext     = 32'(rslot_q);
          cnt_ext      = 32'(cnt_dec);
          scap_d       = rcap_q;
        end
      end
      default: begin
        // query, and the unused code
        if (!found) begin
          status_d = rcsa_pkg::ST_NOTFOUND;
        end else begin
          slot_ext = 32'(rslot_q);
          cnt_ext  = 32'(rcnt_q);
          scap_d   = rcap_q;
        end
      end
    endcase
    // nothing changes until the result register can take the beat
    if (!fire) begin
      wr.we   = 1'b0;
      stk_cmd = '0;
    end
    slot_d = slot_ext[3:0];
    conn_d = cnt_ext[15:0];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      conn_q   <= conn_d;
      scap_q   <= scap_d;
      mis_q    <= mis_d;
      cre_q    <= cre_d;
      rel_q    <= rel_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign slot_o              = slot_q;
  assign connections_o       = conn_q;
  assign stored_capacity_o   = scap_q;
  assign capacity_mismatch_o = mis_q;
  assign created_o           = cre_q;
  assign released_o          = rel_q;

  // Checks
  `RCSA_ASSERT_IMP(a_slots_conserved, clk_i, rst_ni, state_q == S_IDLE,
    $countones(valid_vec) + int'(stk_depth) == CHANNELS, "slot count lost")
  `RCSA_ASSERT_IMP(a_tail_in_scan, clk_i, rst_ni, tok_ctl[CHANNELS].act,
    state_q == S_SCAN, "search token out of scan")
  `RCSA_ASSERT_IMP(a_created_ok, clk_i, rst_ni, out_valid_o && created_o,
    status_o == rcsa_pkg::ST_OK && connections_o == 16'd1 && !released_o,
    "bad create result")
  `RCSA_ASSERT_NXT(a_accept_scan, clk_i, rst_ni, in_acc, state_q == S_SCAN,
    "accept did not start scan")

endmodule
